// ----- hw/rtl/sm3_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm3 package
// shared types, constants and round functions of the sm3 hash engine
// ----------------------------------------------------------------------------
package sm3_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic       put_byte;
        logic [7:0] put_value;
        logic       add_len;
        logic       comp_start;
        logic       comp_round;
        logic       comp_fold;
        logic       reinit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
        logic [63:0] bits;
    } dp_stat_t;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;
    localparam logic [5:0] LEN_POS = 6'd56;

    function automatic logic [31:0] iv_word(input logic [2:0] i);
        logic [31:0] v;
        case (i)
            3'd0: v = 32'h7380166f;
            3'd1: v = 32'h4914b2b9;
            3'd2: v = 32'h172442d7;
            3'd3: v = 32'hda8a0600;
            3'd4: v = 32'ha96f30bc;
            3'd5: v = 32'h163138aa;
            3'd6: v = 32'he38dee4d;
            default: v = 32'hb0fb0e4e;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sm3_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm3 datapath
// block buffer, length counter, message schedule window and round unit
// ----------------------------------------------------------------------------
module sm3_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sm3_pkg::dp_cmd_t cmd,
    input  wire logic [2:0]       rd_index,
    output sm3_pkg::dp_stat_t     stat,
    output logic [31:0]           rd_word
);

    logic [31:0] buf_reg [16];
    logic [31:0] win_reg [16];
    logic [31:0] cv_reg [8];
    logic [31:0] v_reg [8];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [5:0]  rnd_reg;

    logic [3:0]  widx;
    logic [1:0]  bpos;
    logic [31:0] wnew, wj, wj4, tj, a12, s1, s2, ff, gg, t1, t2;
    logic        hi;

    assign widx = fill_reg[5:2];
    assign bpos = fill_reg[1:0];
    assign hi   = rnd_reg[5] | rnd_reg[4];
    assign wj   = win_reg[0];
    assign wj4  = win_reg[4];
    assign wnew = sm3_pkg::perm1(win_reg[0] ^ win_reg[7] ^ sm3_pkg::rotl(win_reg[13], 5'd15))
                  ^ sm3_pkg::rotl(win_reg[3], 5'd7) ^ win_reg[10];
    assign tj   = sm3_pkg::rotl(hi ? sm3_pkg::T_HIGH : sm3_pkg::T_LOW, rnd_reg[4:0]);
    assign a12  = sm3_pkg::rotl(v_reg[0], 5'd12);
    assign s1   = sm3_pkg::rotl(a12 + v_reg[4] + tj, 5'd7);
    assign s2   = s1 ^ a12;
    assign ff   = hi ? ((v_reg[0] & v_reg[1]) | (v_reg[0] & v_reg[2]) | (v_reg[1] & v_reg[2]))
                     : (v_reg[0] ^ v_reg[1] ^ v_reg[2]);
    assign gg   = hi ? ((v_reg[4] & v_reg[5]) | (~v_reg[4] & v_reg[6]))
                     : (v_reg[4] ^ v_reg[5] ^ v_reg[6]);
    assign t1   = ff + v_reg[3] + s2 + (wj ^ wj4);
    assign t2   = gg + v_reg[7] + s1 + wj;

    assign stat.fill       = fill_reg;
    assign stat.round_last = (rnd_reg == 6'd63);
    assign stat.bits       = bits_reg;
    assign rd_word         = cv_reg[rd_index];

    // block buffer, written one byte at a time with message and padding bytes
    always_ff @(posedge clk)
    begin
        if (cmd.put_byte)
        begin
            case (bpos)
                2'd0: buf_reg[widx] <= {cmd.put_value, 24'h0};
                2'd1: buf_reg[widx][23:16] <= cmd.put_value;
                2'd2: buf_reg[widx][15:8] <= cmd.put_value;
                default: buf_reg[widx][7:0] <= cmd.put_value;
            endcase
        end
    end

    // schedule window and working variables
    always_ff @(posedge clk)
    begin
        if (cmd.comp_start)
        begin
            for (int i = 0; i < 16; i++)
                win_reg[i] <= buf_reg[i];
            for (int i = 0; i < 8; i++)
                v_reg[i] <= cv_reg[i];
        end
        else if (cmd.comp_round)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[15] <= wnew;
            v_reg[0] <= t1;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= sm3_pkg::rotl(v_reg[1], 5'd9);
            v_reg[3] <= v_reg[2];
            v_reg[4] <= sm3_pkg::perm0(t2);
            v_reg[5] <= v_reg[4];
            v_reg[6] <= sm3_pkg::rotl(v_reg[5], 5'd19);
            v_reg[7] <= v_reg[6];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                cv_reg[i] <= sm3_pkg::iv_word(3'(i));
            fill_reg <= '0;
            bits_reg <= '0;
            rnd_reg  <= '0;
        end
        else
        begin
            if (cmd.put_byte)
                fill_reg <= fill_reg + 6'd1;
            if (cmd.add_len)
                bits_reg <= bits_reg + 64'd8;
            if (cmd.comp_start)
                rnd_reg <= '0;
            else if (cmd.comp_round)
                rnd_reg <= rnd_reg + 6'd1;
            if (cmd.comp_fold)
                for (int i = 0; i < 8; i++)
                    cv_reg[i] <= cv_reg[i] ^ v_reg[i];
            if (cmd.reinit)
            begin
                for (int i = 0; i < 8; i++)
                    cv_reg[i] <= sm3_pkg::iv_word(3'(i));
                fill_reg <= '0;
                bits_reg <= '0;
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sm3_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm3 controller
// request intake, padding sequence, round sequencing and digest output
// ----------------------------------------------------------------------------
module sm3_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        data_byte,
    input  wire logic              byte_present,
    input  wire logic              last_byte,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [2:0]             word_index,
    output logic                   last_word,
    output logic [2:0]             rd_index,
    output sm3_pkg::dp_cmd_t       cmd,
    input  wire sm3_pkg::dp_stat_t stat
);

    sm3_pkg::ctrl_state_t state_reg, state_next;
    logic        fin_reg, fin_next;      // length tail started, message ends after this block
    logic [63:0] len_reg, len_next;      // bit length latched at end
    logic        mark_reg, mark_next;    // 0x80 still to place
    logic [2:0]  idx_reg, idx_next;
    logic [2:0]  lb;
    logic        acc;

    assign acc        = in_valid & in_ready;
    assign word_index = idx_reg;
    assign last_word  = (idx_reg == 3'd7);
    assign rd_index   = idx_reg;
    assign lb         = 3'd7 - stat.fill[2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sm3_pkg::ST_IDLE;
            fin_reg   <= 1'b0;
            len_reg   <= '0;
            mark_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            len_reg   <= len_next;
            mark_reg  <= mark_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        len_next   = len_reg;
        mark_next  = mark_reg;
        idx_next   = idx_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            sm3_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (acc)
                begin
                    cmd.put_byte  = byte_present;
                    cmd.put_value = data_byte;
                    cmd.add_len   = byte_present;
                    fin_next      = 1'b0;
                    if (last_byte)
                    begin
                        len_next  = stat.bits + (byte_present ? 64'd8 : 64'd0);
                        mark_next = 1'b1;
                    end
                    // block full: load it once the last byte is written
                    if (byte_present && stat.fill == 6'd63)
                        state_next = sm3_pkg::ST_LOAD;
                    else if (last_byte)
                        state_next = sm3_pkg::ST_PAD;
                end
            end
            sm3_pkg::ST_PAD:
            begin
                cmd.put_byte = 1'b1;
                if (mark_reg)
                begin
                    cmd.put_value = sm3_pkg::PAD_MARK;
                    mark_next     = 1'b0;
                end
                else if (fin_reg || stat.fill == sm3_pkg::LEN_POS)
                begin
                    // length tail fills bytes 56 to 63 of the final block
                    cmd.put_value = len_reg[{lb, 3'b000} +: 8];
                    fin_next      = 1'b1;
                end
                else
                    cmd.put_value = 8'h00;
                if (stat.fill == 6'd63)
                    state_next = sm3_pkg::ST_LOAD;
            end
            sm3_pkg::ST_LOAD:
            begin
                cmd.comp_start = 1'b1;
                state_next     = sm3_pkg::ST_COMP;
            end
            sm3_pkg::ST_COMP:
            begin
                cmd.comp_round = 1'b1;
                if (stat.round_last)
                    state_next = sm3_pkg::ST_FOLD;
            end
            sm3_pkg::ST_FOLD:
            begin
                cmd.comp_fold = 1'b1;
                idx_next      = '0;
                // a block that ended in length bytes finishes the message
                if (fin_reg)
                    state_next = sm3_pkg::ST_OUT;
                // padding carries over into the next block
                else if (mark_reg || len_reg != 64'd0)
                    state_next = sm3_pkg::ST_PAD;
                else
                    state_next = sm3_pkg::ST_IDLE;
            end
            sm3_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.reinit = 1'b1;
                        len_next   = '0;
                        fin_next   = 1'b0;
                        state_next = sm3_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = sm3_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sm3_hash_engine_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm3 hash engine
// byte-serial sm3 hash, 256-bit digest delivered as eight 32-bit words
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  input    | in_valid / in_ready   | data_byte, byte_present, last_byte
//  output   | out_valid / out_ready | digest_word, word_index, last_word
//
//  a data byte is taken per accepted input request; the 64th byte of a block
//  adds a load step, the rounds of the single round unit and a fold step
//  a last request adds one padding byte per cycle and, per padded block, a load,
//  the rounds and a fold, then eight digest words, one per accepted output request
//  reset restores the initial value; output stalls hold the digest
//  input is not taken while a block compresses or a digest is pending
// ----------------------------------------------------------------------------
module sm3_hash_engine_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    sm3_pkg::dp_cmd_t  cmd;
    sm3_pkg::dp_stat_t stat;
    logic [2:0]        rd_index;

    // sequencing of bytes, padding and rounds
    sm3_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .word_index   (word_index),
        .last_word    (last_word),
        .rd_index     (rd_index),
        .cmd          (cmd),
        .stat         (stat)
    );

    // buffer, schedule and chaining value
    sm3_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rd_index (rd_index),
        .stat     (stat),
        .rd_word  (digest_word)
    );

endmodule
`default_nettype wire
